>>> hw/rtl/vebc_pkg.sv
package vebc_pkg;

  localparam int FRAC_BITS = 16;
  localparam int COORD_W   = 32;
  localparam int COEF_W    = 18;
  localparam int MUL_W     = COEF_W + COORD_W;
  localparam int SEC_W     = COORD_W + 3;
  localparam int NUM_W     = COORD_W + 1;
  localparam int DIVD_W    = NUM_W + FRAC_BITS;
  localparam int IN_W      = 200;
  localparam int OUT_W     = 136;

  localparam logic signed [COEF_W-1:0] ONE = COEF_W'(1) << FRAC_BITS;
  localparam logic signed [COORD_W-1:0] C_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] C_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  localparam logic [1:0] CFG_X_MIN = 2'd0;
  localparam logic [1:0] CFG_X_MAX = 2'd1;
  localparam logic [1:0] CFG_Y_MIN = 2'd2;
  localparam logic [1:0] CFG_Y_MAX = 2'd3;

  typedef struct packed {
    logic [COEF_W-1:0]  coef_a;
    logic [COEF_W-1:0]  coef_b;
    logic [COORD_W-1:0] coef_c;
    logic               end0_present;
    logic [COORD_W-1:0] end0_x;
    logic [COORD_W-1:0] end0_y;
    logic               end1_present;
    logic [COORD_W-1:0] end1_x;
    logic [COORD_W-1:0] end1_y;
  } edge_t;

  typedef struct packed {
    logic [COORD_W-1:0] x_min;
    logic [COORD_W-1:0] x_max;
    logic [COORD_W-1:0] y_min;
    logic [COORD_W-1:0] y_max;
  } win_t;

  typedef struct packed {
    logic               ok;
    logic               a_one;
    logic               res1;
    logic               res2;
    logic               neg1;
    logic               neg2;
    logic [COORD_W-1:0] a1;
    logic [COORD_W-1:0] a2;
    logic [COORD_W-1:0] s1;
    logic [COORD_W-1:0] s2;
  } side_t;

  function automatic logic [COORD_W-1:0] sat_sec(input logic signed [SEC_W-1:0] v);
    logic [COORD_W-1:0] r;
    if (v > SEC_W'(C_MAX)) r = C_MAX;
    else if (v < SEC_W'(C_MIN)) r = C_MIN;
    else r = v[COORD_W-1:0];
    return r;
  endfunction

  function automatic logic [COORD_W-1:0] sat_quo(input logic [DIVD_W-1:0] q,
                                                 input logic neg);
    logic [COORD_W-1:0] r;
    if (!neg) begin
      if (q > DIVD_W'(C_MAX)) r = C_MAX;
      else r = q[COORD_W-1:0];
    end else begin
      if (q > (DIVD_W'(1) << (COORD_W - 1))) r = C_MIN;
      else r = -q[COORD_W-1:0];
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/voronoi_edge_box_clip_core.sv
// Pipeline from input beat to result beat: 4 front stages, 49 divider
// stages, 1 output stage.
// Throughput: one edge per cycle; the whole pipeline holds while a result waits.
// Reset (rst, synchronous): pipeline emptied, window set to [0,1] x [0,1].
module voronoi_edge_box_clip_core
  import vebc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // coef_a, coef_b, coef_c, end0_present, end0_x, end0_y, end1_present, end1_x, end1_y
  input  logic [IN_W-1:0]      s_tdata,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // visible, seg_x_start, seg_y_start, seg_x_end, seg_y_end
  output logic [OUT_W-1:0]     m_tdata,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [COORD_W-1:0]   cfg_data
);

  logic              en, f_valid;
  edge_t             din;
  win_t              win;
  side_t             f_side;
  logic [DIVD_W-1:0] dvd1, dvd2, q1, q2;
  logic [COEF_W-1:0] dvs;

  logic  d_valid [DIVD_W];
  side_t d_side  [DIVD_W];

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  assign din.coef_a       = s_tdata[17:0];
  assign din.coef_b       = s_tdata[35:18];
  assign din.coef_c       = s_tdata[67:36];
  assign din.end0_present = s_tdata[68];
  assign din.end0_x       = s_tdata[100:69];
  assign din.end0_y       = s_tdata[132:101];
  assign din.end1_present = s_tdata[133];
  assign din.end1_x       = s_tdata[165:134];
  assign din.end1_y       = s_tdata[197:166];

  always_ff @(posedge clk) begin
    if (rst) begin
      win.x_min <= '0;
      win.x_max <= COORD_W'(1) << FRAC_BITS;
      win.y_min <= '0;
      win.y_max <= COORD_W'(1) << FRAC_BITS;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_X_MIN: win.x_min <= cfg_data;
        CFG_X_MAX: win.x_max <= cfg_data;
        CFG_Y_MIN: win.y_min <= cfg_data;
        CFG_Y_MAX: win.y_max <= cfg_data;
        default: ;
      endcase
    end
  end

  vebc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_tvalid),
    .din       (din),
    .win       (win),
    .out_valid (f_valid),
    .side      (f_side),
    .dvd1      (dvd1),
    .dvd2      (dvd2),
    .dvs       (dvs)
  );

  vebc_div u_div1 (.clk(clk), .en(en), .dvd(dvd1), .dvs(dvs), .quo(q1));
  vebc_div u_div2 (.clk(clk), .en(en), .dvd(dvd2), .dvs(dvs), .quo(q2));

  // sideband follows the divider stages
  for (genvar i = 0; i < DIVD_W; i++) begin : g_delay
    always_ff @(posedge clk) begin
      if (rst) begin
        d_valid[i] <= 1'b0;
      end else if (en) begin
        d_valid[i] <= (i == 0) ? f_valid : d_valid[(i == 0) ? 0 : i - 1];
      end
      if (en) begin
        d_side[i] <= (i == 0) ? f_side : d_side[(i == 0) ? 0 : i - 1];
      end
    end
  end

  vebc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (d_valid[DIVD_W-1]),
    .side      (d_side[DIVD_W-1]),
    .q1        (q1),
    .q2        (q2),
    .out_valid (m_tvalid),
    .out_data  (m_tdata)
  );

endmodule

>>> hw/rtl/vebc_front.sv
module vebc_front
  import vebc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  edge_t             din,
  input  win_t              win,
  output logic              out_valid,
  output side_t             side,
  output logic [DIVD_W-1:0] dvd1,
  output logic [DIVD_W-1:0] dvd2,
  output logic [COEF_W-1:0] dvs
);

  logic v1, v2, v3;

  // stage 1: axis select, primary limits
  logic                       a_one, swap, e1, e2, rej;
  logic signed [COORD_W-1:0]  ep1, ep2, plo, phi, a1, a2;
  logic                       s1_a_one, s1_rej;
  logic signed [COEF_W-1:0]   s1_coef;
  logic signed [COORD_W-1:0]  s1_c, s1_a1, s1_a2;

  always_comb begin
    a_one = $signed(din.coef_a) == ONE;
    swap  = a_one && !din.coef_b[COEF_W-1];
    e1    = swap ? din.end1_present : din.end0_present;
    e2    = swap ? din.end0_present : din.end1_present;
    ep1   = a_one ? (swap ? din.end1_y : din.end0_y) : din.end0_x;
    ep2   = a_one ? (swap ? din.end0_y : din.end1_y) : din.end1_x;
    plo   = a_one ? win.y_min : win.x_min;
    phi   = a_one ? win.y_max : win.x_max;
    a1    = (e1 && ep1 > plo) ? ep1 : plo;
    a2    = (e2 && ep2 < phi) ? ep2 : phi;
    rej   = (a1 > phi) || (a2 < plo);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
    if (en) begin
      s1_a_one <= a_one;
      s1_rej   <= rej;
      s1_coef  <= a_one ? din.coef_b : din.coef_a;
      s1_c     <= din.coef_c;
      s1_a1    <= a1;
      s1_a2    <= a2;
    end
  end

  // stage 2: products
  logic                       s2_a_one, s2_rej;
  logic signed [COEF_W-1:0]   s2_coef;
  logic signed [COORD_W-1:0]  s2_c, s2_a1, s2_a2;
  logic signed [MUL_W-1:0]    s2_p1, s2_p2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
    if (en) begin
      s2_a_one <= s1_a_one;
      s2_rej   <= s1_rej;
      s2_coef  <= s1_coef;
      s2_c     <= s1_c;
      s2_a1    <= s1_a1;
      s2_a2    <= s1_a2;
      s2_p1    <= MUL_W'(s1_coef) * MUL_W'(s1_a1);
      s2_p2    <= MUL_W'(s1_coef) * MUL_W'(s1_a2);
    end
  end

  // stage 3: secondary coordinate, floor shift
  logic                       s3_a_one, s3_rej;
  logic signed [COEF_W-1:0]   s3_coef;
  logic signed [COORD_W-1:0]  s3_c, s3_a1, s3_a2;
  logic signed [SEC_W-1:0]    s3_b1, s3_b2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
    if (en) begin
      s3_a_one <= s2_a_one;
      s3_rej   <= s2_rej;
      s3_coef  <= s2_coef;
      s3_c     <= s2_c;
      s3_a1    <= s2_a1;
      s3_a2    <= s2_a2;
      s3_b1    <= SEC_W'(s2_c) - SEC_W'(s2_p1 >>> FRAC_BITS);
      s3_b2    <= SEC_W'(s2_c) - SEC_W'(s2_p2 >>> FRAC_BITS);
    end
  end

  // stage 4: window test, clamp targets, divider operands
  logic signed [COORD_W-1:0] slo, shi, t1, t2;
  logic signed [SEC_W-1:0]   slo_e, shi_e;
  logic signed [NUM_W-1:0]   n1, n2;
  logic                      hi1, lo1, hi2, lo2, nz;
  logic [NUM_W-1:0]          m1, m2;

  always_comb begin
    slo   = s3_a_one ? win.x_min : win.y_min;
    shi   = s3_a_one ? win.x_max : win.y_max;
    slo_e = SEC_W'(slo);
    shi_e = SEC_W'(shi);
    hi1   = s3_b1 > shi_e;
    lo1   = s3_b1 < slo_e;
    hi2   = s3_b2 > shi_e;
    lo2   = s3_b2 < slo_e;
    t1    = (hi1 && !(shi < slo)) ? shi : slo;
    t2    = (hi2 && !(shi < slo)) ? shi : slo;
    n1    = NUM_W'(s3_c) - NUM_W'(t1);
    n2    = NUM_W'(s3_c) - NUM_W'(t2);
    m1    = n1[NUM_W-1] ? -n1 : n1;
    m2    = n2[NUM_W-1] ? -n2 : n2;
    nz    = s3_coef != '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v3;
    end
    if (en) begin
      side.ok    <= !s3_rej && !((hi1 && hi2) || (lo1 && lo2));
      side.a_one <= s3_a_one;
      side.res1  <= (hi1 || lo1) && nz;
      side.res2  <= (hi2 || lo2) && nz;
      side.neg1  <= n1[NUM_W-1] ^ s3_coef[COEF_W-1];
      side.neg2  <= n2[NUM_W-1] ^ s3_coef[COEF_W-1];
      side.a1    <= s3_a1;
      side.a2    <= s3_a2;
      side.s1    <= (hi1 || lo1) ? t1 : sat_sec(s3_b1);
      side.s2    <= (hi2 || lo2) ? t2 : sat_sec(s3_b2);
      dvd1       <= {m1, {FRAC_BITS{1'b0}}};
      dvd2       <= {m2, {FRAC_BITS{1'b0}}};
      dvs        <= s3_coef[COEF_W-1] ? -s3_coef : s3_coef;
    end
  end

endmodule

>>> hw/rtl/vebc_div.sv
module vebc_div
  import vebc_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  logic [DIVD_W-1:0] dvd,
  input  logic [COEF_W-1:0] dvs,
  output logic [DIVD_W-1:0] quo
);

  // restoring divider, one quotient bit per stage
  logic [COEF_W-1:0] rem [DIVD_W];
  logic [DIVD_W-1:0] dq  [DIVD_W];
  logic [COEF_W-1:0] dv  [DIVD_W];

  for (genvar i = 0; i < DIVD_W; i++) begin : g_stage
    logic [COEF_W-1:0] rem_in, dv_in;
    logic [DIVD_W-1:0] dq_in;
    logic [COEF_W:0]   trial;
    logic              ge;

    if (i == 0) begin : g_first
      assign rem_in = '0;
      assign dq_in  = dvd;
      assign dv_in  = dvs;
    end else begin : g_next
      assign rem_in = rem[i-1];
      assign dq_in  = dq[i-1];
      assign dv_in  = dv[i-1];
    end

    assign trial = {rem_in, dq_in[DIVD_W-1]};
    assign ge    = trial >= {1'b0, dv_in};

    always_ff @(posedge clk) begin
      if (en) begin
        rem[i] <= ge ? COEF_W'(trial - {1'b0, dv_in}) : trial[COEF_W-1:0];
        dq[i]  <= {dq_in[DIVD_W-2:0], ge};
        dv[i]  <= dv_in;
      end
    end
  end

  assign quo = dq[DIVD_W-1];

endmodule

>>> hw/rtl/vebc_back.sv
module vebc_back
  import vebc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  side_t             side,
  input  logic [DIVD_W-1:0] q1,
  input  logic [DIVD_W-1:0] q2,
  output logic              out_valid,
  output logic [OUT_W-1:0]  out_data
);

  logic [COORD_W-1:0] p1, p2, xs, ys, xe, ye;

  always_comb begin
    p1 = side.res1 ? sat_quo(q1, side.neg1) : side.a1;
    p2 = side.res2 ? sat_quo(q2, side.neg2) : side.a2;
    xs = side.a_one ? side.s1 : p1;
    ys = side.a_one ? p1 : side.s1;
    xe = side.a_one ? side.s2 : p2;
    ye = side.a_one ? p2 : side.s2;
    if (!side.ok) begin
      xs = '0;
      ys = '0;
      xe = '0;
      ye = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
    if (en) begin
      out_data <= {7'b0, ye, xe, ys, xs, side.ok};
    end
  end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import vebc_pkg::*;

  typedef struct {
    logic signed [COEF_W-1:0]  a;
    logic signed [COEF_W-1:0]  b;
    logic signed [COORD_W-1:0] c;
    logic                      p0;
    logic signed [COORD_W-1:0] x0;
    logic signed [COORD_W-1:0] y0;
    logic                      p1;
    logic signed [COORD_W-1:0] x1;
    logic signed [COORD_W-1:0] y1;
  } edge_item_t;

  typedef struct {
    logic                      vis;
    logic signed [COORD_W-1:0] xs;
    logic signed [COORD_W-1:0] ys;
    logic signed [COORD_W-1:0] xe;
    logic signed [COORD_W-1:0] ye;
  } seg_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = CFG_X_MIN;
  logic [COORD_W-1:0] cfg_data = '0;

  longint win_x_lo, win_x_hi, win_y_lo, win_y_hi;
  seg_t expected_segs[$];
  int errors = 0;
  int burst_left = 0;

  voronoi_edge_box_clip_core u_top (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic longint floor_mul(longint coef, longint v);
    longint p, one;
    p = coef * v;
    one = longint'(1) << FRAC_BITS;
    if (p >= 0) return p / one;
    return -((-p + one - 1) / one);
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint solve_primary(longint c, longint s, longint coef, longint keep);
    if (coef == 0) return keep;
    return clamp32(((c - s) * (longint'(1) << FRAC_BITS)) / coef);
  endfunction

  function automatic bit clip_span(longint plo, longint phi, longint slo, longint shi,
                                   longint coef, longint c, bit e1, longint e1p,
                                   bit e2, longint e2p, output longint p1,
                                   output longint s1, output longint p2,
                                   output longint s2);
    longint q1, q2, r1, r2;
    q1 = plo;
    q2 = phi;
    p1 = 0; s1 = 0; p2 = 0; s2 = 0;
    if (e1 && e1p > plo) q1 = e1p;
    if (q1 > phi) return 1'b0;
    r1 = c - floor_mul(coef, q1);
    if (e2 && e2p < phi) q2 = e2p;
    if (q2 < plo) return 1'b0;
    r2 = c - floor_mul(coef, q2);
    if ((r1 > shi && r2 > shi) || (r1 < slo && r2 < slo)) return 1'b0;
    if (r1 > shi) begin r1 = shi; q1 = solve_primary(c, r1, coef, q1); end
    if (r1 < slo) begin r1 = slo; q1 = solve_primary(c, r1, coef, q1); end
    if (r2 > shi) begin r2 = shi; q2 = solve_primary(c, r2, coef, q2); end
    if (r2 < slo) begin r2 = slo; q2 = solve_primary(c, r2, coef, q2); end
    p1 = q1; s1 = clamp32(r1); p2 = q2; s2 = clamp32(r2);
    return 1'b1;
  endfunction

  function automatic seg_t clip_edge(edge_item_t e);
    seg_t r;
    bit a_one, ea, eb, ok;
    longint ax, ay, bx, by, xs, ys, xe, ye;
    a_one = (e.a == ONE);
    if (a_one && e.b >= 0) begin
      ea = e.p1; ax = e.x1; ay = e.y1; eb = e.p0; bx = e.x0; by = e.y0;
    end else begin
      ea = e.p0; ax = e.x0; ay = e.y0; eb = e.p1; bx = e.x1; by = e.y1;
    end
    if (a_one)
      ok = clip_span(win_y_lo, win_y_hi, win_x_lo, win_x_hi, e.b, e.c, ea, ay, eb, by,
                     ys, xs, ye, xe);
    else
      ok = clip_span(win_x_lo, win_x_hi, win_y_lo, win_y_hi, e.a, e.c, ea, ax, eb, bx,
                     xs, ys, xe, ye);
    r.vis = ok;
    r.xs = ok ? xs[31:0] : '0;
    r.ys = ok ? ys[31:0] : '0;
    r.xe = ok ? xe[31:0] : '0;
    r.ye = ok ? ye[31:0] : '0;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  task automatic send_edge(edge_item_t e);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 6)) : 0;
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    s_tdata <= {e.y1, e.x1, e.p1, e.y0, e.x0, e.p0, e.c, e.b, e.a};
    s_tvalid <= 1'b1;
    expected_segs.push_back(clip_edge(e));
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic end_send;
    s_tvalid <= 1'b0;
    burst_left = 0;
  endtask

  task automatic drain;
    while (expected_segs.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic write_window(longint xl, longint xh, longint yl, longint yh);
    logic [1:0] idx[4];
    longint val[4];
    idx = '{CFG_X_MIN, CFG_X_MAX, CFG_Y_MIN, CFG_Y_MAX};
    val = '{xl, xh, yl, yh};
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= val[i][31:0];
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    win_x_lo = xl; win_x_hi = xh; win_y_lo = yl; win_y_hi = yh;
  endtask

  function automatic edge_item_t make_edge(longint a, longint b, longint c, bit p0,
                                           longint x0, longint y0, bit p1,
                                           longint x1, longint y1);
    edge_item_t e;
    e.a = a[17:0]; e.b = b[17:0]; e.c = c[31:0];
    e.p0 = p0; e.x0 = x0[31:0]; e.y0 = y0[31:0];
    e.p1 = p1; e.x1 = x1[31:0]; e.y1 = y1[31:0];
    return e;
  endfunction

  function automatic longint rand_coord(longint lo, longint hi);
    longint span;
    if ($urandom_range(0, 9) == 0) return $signed($urandom());
    span = hi - lo;
    return lo - span / 4 + longint'($urandom_range(0, 1000)) * (span + span / 2) / 1000;
  endfunction

  function automatic edge_item_t rand_edge();
    longint a, b, cen, c;
    case ($urandom_range(0, 5))
      0, 1: begin a = ONE; b = $signed($urandom_range(0, 131072)) - 65536; end
      2, 3: begin b = ONE; a = $signed($urandom_range(0, 131072)) - 65536; end
      4: begin a = ONE; b = ($urandom_range(0, 1) ? 65536 : -65536); end
      default: begin
        a = $signed($urandom() & 32'h3ffff) - 131072;
        b = $signed($urandom() & 32'h3ffff) - 131072;
      end
    endcase
    cen = (win_x_lo + win_x_hi) / 2 + (win_y_lo + win_y_hi) / 2;
    c = $urandom_range(0, 7) == 0 ? longint'($signed($urandom())) :
        clamp32(cen + rand_coord(win_x_lo, win_x_hi) - (win_x_lo + win_x_hi) / 2);
    return make_edge(a, b, c, $urandom_range(0, 1),
                     rand_coord(win_x_lo, win_x_hi), rand_coord(win_y_lo, win_y_hi),
                     $urandom_range(0, 1),
                     rand_coord(win_x_lo, win_x_hi), rand_coord(win_y_lo, win_y_hi));
  endfunction

  always @(posedge clk) begin
    seg_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      {got.ye, got.xe, got.ys, got.xs, got.vis} = m_tdata[128:0];
      if (expected_segs.size() == 0) begin
        $display("unexpected result beat");
        errors++;
      end else begin
        want = expected_segs.pop_front();
        if (got.vis !== want.vis) report_mismatch("visible", got.vis, want.vis);
        if (got.xs !== want.xs) report_mismatch("seg_x_start", got.xs, want.xs);
        if (got.ys !== want.ys) report_mismatch("seg_y_start", got.ys, want.ys);
        if (got.xe !== want.xe) report_mismatch("seg_x_end", got.xe, want.xe);
        if (got.ye !== want.ye) report_mismatch("seg_y_end", got.ye, want.ye);
      end
    end
  end

  always @(negedge clk) begin
    int phase;
    phase = ($time / 8) % 400;
    if (phase < 80) m_tready <= 1'b1;
    else m_tready <= ($urandom_range(0, 3) != 0);
  end

  task automatic test_default_window;
    longint one;
    one = 65536;
    send_edge(make_edge(one, 0, 32768, 0, 0, 0, 0, 0, 0));
    send_edge(make_edge(0, one, 32768, 0, 0, 0, 0, 0, 0));
    send_edge(make_edge(one, one, one, 1, 0, one, 1, one, 0));
    send_edge(make_edge(one, -one, 0, 1, 16384, 16384, 1, 49152, 49152));
    send_edge(make_edge(-one, one, 0, 1, 16384, 16384, 0, 0, 0));
    send_edge(make_edge(one, 0, 5 * one, 0, 0, 0, 0, 0, 0));
    send_edge(make_edge(0, one, -one, 0, 0, 0, 0, 0, 0));
    send_edge(make_edge(one, 32768, one, 1, 2 * one, 2 * one, 0, 0, 0));
    send_edge(make_edge(one, 32768, one, 0, 0, 0, 1, -one, -one));
    send_edge(make_edge(-65536, 65536, 0, 1, -1, -1, 1, 2 * one, 2 * one));
    send_edge(make_edge(65536, -65536, 32'h7fffffff, 1, 32'h7fffffff, 32'h7fffffff,
                        1, -64'sd2147483648, -64'sd2147483648));
    send_edge(make_edge(1, 65536, 32768, 0, 0, 0, 0, 0, 0));
    send_edge(make_edge(0, 0, 0, 1, 0, 0, 1, one, one));
    send_edge(make_edge(-131072, 131071, -1, 1, 32768, 0, 1, 32768, one));
    send_edge(make_edge(one, 1, 100, 0, 0, 0, 0, 0, 0));
    end_send();
    drain();
  endtask

  task automatic test_windows;
    write_window(-64'sd2147483648, 64'sd2147483647, -64'sd2147483648, 64'sd2147483647);
    for (int i = 0; i < 200; i++) send_edge(rand_edge());
    end_send(); drain();
    write_window(65536, 0, 0, 65536);
    for (int i = 0; i < 50; i++) send_edge(rand_edge());
    end_send(); drain();
    write_window(-10 * 65536, 10 * 65536, -5 * 65536, 20 * 65536);
    for (int i = 0; i < 250; i++) send_edge(rand_edge());
    end_send(); drain();
  endtask

  task automatic test_random;
    for (int k = 0; k < 4; k++) begin
      longint xl, yl;
      xl = $signed($urandom()) / 4;
      yl = $signed($urandom()) / 4;
      write_window(xl, xl + $urandom_range(1, 1 << 24), yl, yl + $urandom_range(1, 1 << 24));
      for (int i = 0; i < 200; i++) send_edge(rand_edge());
      end_send(); drain();
    end
  endtask

  initial begin
    win_x_lo = 0; win_x_hi = 65536; win_y_lo = 0; win_y_hi = 65536;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_default_window();
    test_windows();
    test_random();
    if (errors == 0) $display("tb_top passed");
    else $display("tb_top failed");
    $finish;
  end

  initial begin
    #5ms;
    $display("tb_top failed");
    $finish;
  end

endmodule

>>> voronoi_edge_box_clip_core.f
hw/rtl/vebc_pkg.sv
hw/rtl/vebc_front.sv
hw/rtl/vebc_div.sv
hw/rtl/vebc_back.sv
hw/rtl/voronoi_edge_box_clip_core.sv
tb/tb_top.sv
